// File: src/mhrk_pkg.sv
// Package with the transaction types, operation codes and register map of the heap block.
package mhrk_pkg;

    // Operation codes carried in the operation field of an input transaction.
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_REPLACE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    // Register map of the configuration port.
    localparam int         CFG_ADDR_W      = 2;
    localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;

    localparam int COUNT_W = 7;
    localparam int INDEX_W = 6;
    localparam int WORD_W  = 32;

    typedef struct packed {
        logic [1:0]               operation;
        logic [INDEX_W-1:0]       index;
        logic signed [WORD_W-1:0] value;
        logic signed [WORD_W-1:0] replacement;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        logic                     found;
        logic [INDEX_W-1:0]       final_position;
    } out_item_t;

endpackage

// File: src/mhrk_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module mhrk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/mhrk_cfg.sv
// Configuration register file holding the heap entry count.
module mhrk_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mhrk_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output logic [mhrk_pkg::COUNT_W-1:0]        entry_count
);

    import mhrk_pkg::*;

    logic [COUNT_W-1:0] entry_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr == REG_ENTRY_COUNT))
        begin
            entry_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_ENTRY_COUNT: prdata = 32'(entry_count_reg);
            default:         prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign entry_count = entry_count_reg;

endmodule

// File: src/mhrk_seq.sv
// Sequencer that runs write, read and replace transactions against the heap RAM.
module mhrk_seq #(
    parameter int NODES      = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    input  mhrk_pkg::in_item_t               item,
    output logic                             item_stall,
    input  logic [mhrk_pkg::COUNT_W-1:0]     entry_count,
    output logic                             ram_wr_en,
    output logic [$clog2(NODES)-1:0]         ram_wr_addr,
    output logic [VALUE_BITS-1:0]            ram_wr_data,
    output logic [$clog2(NODES)-1:0]         ram_rd_addr,
    input  logic [VALUE_BITS-1:0]            ram_rd_data,
    output logic                             res_valid,
    output mhrk_pkg::out_item_t              res,
    input  logic                             res_take
);

    import mhrk_pkg::*;

    localparam int ADDR_W  = $clog2(NODES);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int CHILD_W = ADDR_W + 2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_READ_DATA,
        ST_SCAN,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_L,
        ST_DN_R,
        ST_DN_CMP,
        ST_FINISH,
        ST_DONE
    } state_t;

    state_t                        state_reg,    state_next;
    logic [ADDR_W-1:0]             idx_reg,      idx_next;
    logic                          idx_ok_reg,   idx_ok_next;
    logic signed [VALUE_BITS-1:0]  key_reg,      key_next;
    logic signed [VALUE_BITS-1:0]  cur_reg,      cur_next;
    logic signed [VALUE_BITS-1:0]  left_val_reg, left_val_next;
    logic [CNT_W-1:0]              n_reg,        n_next;
    logic [CNT_W-1:0]              scan_reg,     scan_next;
    logic                          cmp_valid_reg, cmp_valid_next;
    logic [ADDR_W-1:0]             cmp_idx_reg,  cmp_idx_next;
    logic [ADDR_W-1:0]             pos_reg,      pos_next;
    out_item_t                     res_reg,      res_next;

    logic signed [VALUE_BITS-1:0]  rd_val;
    logic signed [VALUE_BITS-1:0]  child_val;
    logic [ADDR_W-1:0]             child_idx;
    logic                          pick_left;
    logic [ADDR_W-1:0]             parent_idx;
    logic [CHILD_W-1:0]            left_idx;
    logic [CHILD_W-1:0]            right_idx;
    logic                          left_ok;
    logic                          right_ok;
    logic [CNT_W-1:0]              count_clip;
    logic                          in_idx_ok;

    assign rd_val     = $signed(ram_rd_data);
    assign parent_idx = ADDR_W'((pos_reg - ADDR_W'(1)) >> 1);
    assign left_idx   = CHILD_W'({pos_reg, 1'b1});
    assign right_idx  = left_idx + CHILD_W'(1);
    assign left_ok    = left_idx < CHILD_W'(n_reg);
    assign right_ok   = right_idx < CHILD_W'(n_reg);
    assign count_clip = (32'(entry_count) > 32'(NODES)) ? CNT_W'(NODES) : CNT_W'(entry_count);
    assign in_idx_ok  = 32'(item.index) < 32'(NODES);

    // The left child wins only when strictly smaller than the right one.
    assign pick_left = left_val_reg < rd_val;
    assign child_val = pick_left ? left_val_reg : rd_val;
    assign child_idx = pick_left ? left_idx[ADDR_W-1:0] : right_idx[ADDR_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        idx_ok_next    = idx_ok_reg;
        key_next       = key_reg;
        cur_next       = cur_reg;
        left_val_next  = left_val_reg;
        n_next         = n_reg;
        scan_next      = scan_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        pos_next       = pos_reg;
        res_next       = res_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = pos_reg;
        ram_wr_data    = cur_reg;
        ram_rd_addr    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    idx_next       = ADDR_W'(item.index);
                    idx_ok_next    = in_idx_ok;
                    key_next       = VALUE_BITS'(item.value);
                    cur_next       = VALUE_BITS'(item.replacement);
                    n_next         = count_clip;
                    scan_next      = '0;
                    cmp_valid_next = 1'b0;
                    res_next       = '0;
                    unique case (item.operation)
                        OP_WRITE:   state_next = ST_WRITE;
                        OP_READ:    state_next = ST_READ;
                        OP_REPLACE: state_next = ST_SCAN;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end

            ST_WRITE:
            begin
                ram_wr_en   = idx_ok_reg;
                ram_wr_addr = idx_reg;
                ram_wr_data = key_reg;
                state_next  = ST_DONE;
            end

            ST_READ:
            begin
                ram_rd_addr = idx_reg;
                state_next  = ST_READ_DATA;
            end

            ST_READ_DATA:
            begin
                if (idx_ok_reg)
                begin
                    res_next.read_value = 32'(rd_val);
                end
                state_next = ST_DONE;
            end

            // One read is issued per cycle and its data is compared in the following cycle.
            ST_SCAN:
            begin
                ram_rd_addr = scan_reg[ADDR_W-1:0];
                if (cmp_valid_reg && (ram_rd_data == key_reg))
                begin
                    pos_next   = cmp_idx_reg;
                    state_next = ST_UP_RD;
                end
                else if (scan_reg >= n_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    scan_next      = scan_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_reg[ADDR_W-1:0];
                end
            end

            ST_UP_RD:
            begin
                if (pos_reg != '0)
                begin
                    ram_rd_addr = parent_idx;
                    state_next  = ST_UP_CMP;
                end
                else
                begin
                    state_next = ST_DN_L;
                end
            end

            ST_UP_CMP:
            begin
                if (rd_val > cur_reg)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = ram_rd_data;
                    pos_next    = parent_idx;
                    state_next  = ST_UP_RD;
                end
                else
                begin
                    state_next = ST_DN_L;
                end
            end

            ST_DN_L:
            begin
                if (left_ok)
                begin
                    ram_rd_addr = left_idx[ADDR_W-1:0];
                    state_next  = ST_DN_R;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_DN_R:
            begin
                if (right_ok)
                begin
                    ram_rd_addr   = right_idx[ADDR_W-1:0];
                    left_val_next = rd_val;
                    state_next    = ST_DN_CMP;
                end
                else if (cur_reg > rd_val)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = ram_rd_data;
                    pos_next    = left_idx[ADDR_W-1:0];
                    state_next  = ST_DN_L;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_DN_CMP:
            begin
                if (cur_reg > child_val)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = child_val;
                    pos_next    = child_idx;
                    state_next  = ST_DN_L;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                ram_wr_en               = 1'b1;
                res_next.found          = 1'b1;
                res_next.final_position = INDEX_W'(pos_reg);
                state_next              = ST_DONE;
            end

            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            idx_ok_reg    <= 1'b0;
            key_reg       <= '0;
            cur_reg       <= '0;
            left_val_reg  <= '0;
            n_reg         <= '0;
            scan_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            pos_reg       <= '0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            idx_ok_reg    <= idx_ok_next;
            key_reg       <= key_next;
            cur_reg       <= cur_next;
            left_val_reg  <= left_val_next;
            n_reg         <= n_next;
            scan_reg      <= scan_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_idx_reg   <= cmp_idx_next;
            pos_reg       <= pos_next;
            res_reg       <= res_next;
        end
    end

    assign item_stall = (state_reg != ST_IDLE);
    assign res_valid  = (state_reg == ST_DONE);
    assign res        = res_reg;

endmodule

// File: src/min_heap_replace_key_core.sv
// Top level of the binary min-heap block with replace-key search and sift.
//
//   Channel   Direction  Handshake                     Payload
//   item      in         item_valid / item_stall       mhrk_pkg::in_item_t
//   result    out        result_valid / result_stall   mhrk_pkg::out_item_t
//   config    in         APB psel/penable/pready       entry_count at byte address 0
//
// One transaction is worked on at a time, paced by the single read port of the heap RAM.
// A replace scans one entry a cycle over the n entries in use; a miss ends the scan, while a
// hit at position p sifts the replacement up, comparing with each parent, and then down, comparing
// each child pair (or a lone left child), and writes it at its final position.
// An output register holds one finished result, so a stalled result blocks the input only
// once the next is finished too. Reset clears control state and entry count, not the RAM.
module min_heap_replace_key_core #(
    parameter int NODES      = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  mhrk_pkg::in_item_t              item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output mhrk_pkg::out_item_t             result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mhrk_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    import mhrk_pkg::*;

    localparam int ADDR_W = $clog2(NODES);

    logic [COUNT_W-1:0]    entry_count;
    logic                  ram_wr_en;
    logic [ADDR_W-1:0]     ram_wr_addr;
    logic [VALUE_BITS-1:0] ram_wr_data;
    logic [ADDR_W-1:0]     ram_rd_addr;
    logic [VALUE_BITS-1:0] ram_rd_data;
    logic                  res_valid;
    out_item_t             res;
    logic                  res_take;

    logic                  out_valid_reg;
    out_item_t             out_item_reg;

    // The register file holds the number of heap entries in use.
    mhrk_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .entry_count (entry_count)
    );

    // The heap itself lives in one RAM with a registered read.
    mhrk_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (NODES)
    ) u_heap_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // The sequencer never uses read data from an entry written in the same cycle: each
    // write lands at the clock edge before any read whose data it matters to, so the
    // read-modify-write of the sift needs no forwarding path.
    mhrk_seq #(
        .NODES      (NODES),
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item        (item),
        .item_stall  (item_stall),
        .entry_count (entry_count),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .res_valid   (res_valid),
        .res         (res),
        .res_take    (res_take)
    );

    // The output register takes a result whenever it is empty or being emptied.
    assign res_take = res_valid && (!out_valid_reg || !result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
            out_item_reg  <= res;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule
